/* sv/eia_pkg.sv */
// ----------------------------------------------------------------------------
// eia_pkg: shared definitions for the expression integer ALU
// Opcodes, status codes, result selectors and the per-stage control group.
// ----------------------------------------------------------------------------
`default_nettype none

package eia_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int OP_WIDTH       = 5;
  localparam int ST_WIDTH       = 2;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0,
    OP_SUB = 5'd1,
    OP_MUL = 5'd2,
    OP_DIV = 5'd3,
    OP_MOD = 5'd4,
    OP_POW = 5'd5,
    OP_INC = 5'd6,
    OP_DEC = 5'd7,
    OP_NOT = 5'd8,
    OP_GT  = 5'd9,
    OP_GE  = 5'd10,
    OP_LT  = 5'd11,
    OP_LE  = 5'd12,
    OP_EQ  = 5'd13,
    OP_NE  = 5'd14,
    OP_AND = 5'd15,
    OP_OR  = 5'd16
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV0     = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OVERFLOW = 2'd3
  } st_t;

  // Which pipeline product forms the final value.
  typedef enum logic [1:0] {
    SEL_SIMPLE = 2'd0,
    SEL_DIV    = 2'd1,
    SEL_MOD    = 2'd2,
    SEL_POW    = 2'd3
  } sel_t;

  typedef struct packed {
    logic valid;
    sel_t sel;
    st_t  status;
    logic neg;
  } ctl_t;

endpackage

`default_nettype wire

/* sv/eia_stage.sv */
// ----------------------------------------------------------------------------
// eia_stage: one pipeline stage of the ALU
// Retires one quotient bit of the restoring divider and one exponent bit of
// the square-and-multiply power unit.
// ----------------------------------------------------------------------------
`default_nettype none

module eia_stage #(
  parameter int W = eia_pkg::DATA_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire eia_pkg::ctl_t ctl_i,
  input  wire logic [W-1:0]  simple_i,
  input  wire logic [W-1:0]  rem_i,
  input  wire logic [W-1:0]  quo_i,
  input  wire logic [W-1:0]  dvs_i,
  input  wire logic [W-1:0]  acc_i,
  input  wire logic [W-1:0]  base_i,
  input  wire logic [W-1:0]  ex_i,
  output eia_pkg::ctl_t      ctl_o,
  output logic      [W-1:0]  simple_o,
  output logic      [W-1:0]  rem_o,
  output logic      [W-1:0]  quo_o,
  output logic      [W-1:0]  dvs_o,
  output logic      [W-1:0]  acc_o,
  output logic      [W-1:0]  base_o,
  output logic      [W-1:0]  ex_o
);

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] acc_nxt;
  logic [W-1:0] base_nxt;

  eia_pkg::ctl_t ctl_r;
  logic [W-1:0]  simple_r, rem_r, quo_r, dvs_r, acc_r, base_r, ex_r;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial   = {rem_i, quo_i[W-1]};
    diff    = trial - {1'b0, dvs_i};
    fits    = ~diff[W];
    rem_nxt = fits ? diff[W-1:0] : trial[W-1:0];
    acc_nxt = ex_i[0] ? W'(acc_i * base_i) : acc_i;
    base_nxt = W'(base_i * base_i);
  end

  // Only the valid bit is reset; the payload simply follows the enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
    if (en) begin
      ctl_r.sel    <= ctl_i.sel;
      ctl_r.status <= ctl_i.status;
      ctl_r.neg    <= ctl_i.neg;
      simple_r     <= simple_i;
      rem_r        <= rem_nxt;
      quo_r        <= {quo_i[W-2:0], fits};
      dvs_r        <= dvs_i;
      acc_r        <= acc_nxt;
      base_r       <= base_nxt;
      ex_r         <= {1'b0, ex_i[W-1:1]};
    end
  end

  assign ctl_o    = ctl_r;
  assign simple_o = simple_r;
  assign rem_o    = rem_r;
  assign quo_o    = quo_r;
  assign dvs_o    = dvs_r;
  assign acc_o    = acc_r;
  assign base_o   = base_r;
  assign ex_o     = ex_r;

endmodule

`default_nettype wire

/* sv/expression_integer_alu_top.sv */
// ----------------------------------------------------------------------------
// expression_integer_alu_top: pipelined signed integer ALU
// Add, subtract, multiply, divide, remainder, power, increment, decrement,
// logical not, comparisons and logical and/or with a status per result.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_ stream: an opcode and two signed operands. Each
// request produces exactly one result on the out_ stream: a value and a
// status (ok, divide by zero, invalid operator, overflow). Erroneous
// requests return a zero value.
// The datapath is a single pipeline: one decode stage, DATA_WIDTH identical
// stages and one output register. Each middle stage retires one quotient bit
// of a restoring divider and one exponent bit of a square-and-multiply power
// unit, which is what sets the depth. A new request is taken every cycle
// unless the receiver stalls the output.
// The whole pipeline advances together whenever the output register is
// empty or being drained, so a stall from the receiver freezes every stage
// and in_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears every stage valid bit; the block is ready the cycle after
// reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_integer_alu_top #(
  parameter int DATA_WIDTH = eia_pkg::DATA_WIDTH_DEF,
  localparam int IN_BITS   = ((eia_pkg::OP_WIDTH + 2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS  = ((DATA_WIDTH + eia_pkg::ST_WIDTH + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // Fields from bit 0: req_type, left_operand, right_operand, zero padding.
  input  wire logic [IN_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // Fields from bit 0: value, status, zero padding.
  output logic      [OUT_BITS-1:0] out_tdata
);

  localparam int W  = DATA_WIDTH;
  localparam int OW = eia_pkg::OP_WIDTH;

  // The pipeline moves as one whenever the output slot can take a result.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Decode stage.
  logic [OW-1:0] op;
  logic [W-1:0]  a, b;
  logic          aneg, bneg;
  logic [W-1:0]  a_mag, b_mag;
  logic [W-1:0]  all_ones, int_min, one_w;
  eia_pkg::ctl_t ctl_nxt;
  logic [W-1:0]  simple_nxt;

  assign op       = in_tdata[OW-1:0];
  assign a        = in_tdata[OW +: W];
  assign b        = in_tdata[OW+W +: W];
  assign aneg     = a[W-1];
  assign bneg     = b[W-1];
  assign a_mag    = aneg ? W'(-a) : a;
  assign b_mag    = bneg ? W'(-b) : b;
  assign all_ones = '1;
  assign int_min  = {1'b1, {(W-1){1'b0}}};
  assign one_w    = W'(1);

  always_comb begin
    ctl_nxt.valid  = in_tvalid;
    ctl_nxt.sel    = eia_pkg::SEL_SIMPLE;
    ctl_nxt.status = eia_pkg::ST_OK;
    ctl_nxt.neg    = 1'b0;
    simple_nxt     = '0;
    unique case (eia_pkg::op_t'(op))
      eia_pkg::OP_ADD: simple_nxt = W'(a + b);
      eia_pkg::OP_SUB: simple_nxt = W'(a - b);
      eia_pkg::OP_MUL: simple_nxt = W'(a * b);
      eia_pkg::OP_DIV: begin
        ctl_nxt.sel = eia_pkg::SEL_DIV;
        ctl_nxt.neg = aneg ^ bneg;
        if (b == '0) begin
          ctl_nxt.status = eia_pkg::ST_DIV0;
        end else if (a == int_min && b == all_ones) begin
          ctl_nxt.status = eia_pkg::ST_OVERFLOW;
        end
      end
      eia_pkg::OP_MOD: begin
        // The most negative value mod minus one falls out of the divider as 0.
        ctl_nxt.sel = eia_pkg::SEL_MOD;
        ctl_nxt.neg = aneg;
        if (b == '0) begin
          ctl_nxt.status = eia_pkg::ST_DIV0;
        end
      end
      eia_pkg::OP_POW: begin
        if (bneg) begin
          // Negative exponent: only bases of one and minus one survive.
          if (a == one_w) begin
            simple_nxt = one_w;
          end else if (a == all_ones) begin
            simple_nxt = b[0] ? all_ones : one_w;
          end else if (a == '0) begin
            ctl_nxt.status = eia_pkg::ST_DIV0;
          end
        end else begin
          ctl_nxt.sel = eia_pkg::SEL_POW;
        end
      end
      eia_pkg::OP_INC: simple_nxt = W'(a + one_w);
      eia_pkg::OP_DEC: simple_nxt = W'(a - one_w);
      eia_pkg::OP_NOT: simple_nxt = W'(a == '0);
      eia_pkg::OP_GT:  simple_nxt = W'($signed(a) > $signed(b));
      eia_pkg::OP_GE:  simple_nxt = W'($signed(a) >= $signed(b));
      eia_pkg::OP_LT:  simple_nxt = W'($signed(a) < $signed(b));
      eia_pkg::OP_LE:  simple_nxt = W'($signed(a) <= $signed(b));
      eia_pkg::OP_EQ:  simple_nxt = W'(a == b);
      eia_pkg::OP_NE:  simple_nxt = W'(a != b);
      eia_pkg::OP_AND: simple_nxt = W'(a != '0 && b != '0);
      eia_pkg::OP_OR:  simple_nxt = W'(a != '0 || b != '0);
      default:         ctl_nxt.status = eia_pkg::ST_INVALID;
    endcase
  end

  // Stage arrays: index 0 is the decode register, index W the last stage.
  eia_pkg::ctl_t ctl_s    [W+1];
  logic [W-1:0]  simple_s [W+1];
  logic [W-1:0]  rem_s    [W+1];
  logic [W-1:0]  quo_s    [W+1];
  logic [W-1:0]  dvs_s    [W+1];
  logic [W-1:0]  acc_s    [W+1];
  logic [W-1:0]  base_s   [W+1];
  logic [W-1:0]  ex_s     [W+1];

  eia_pkg::ctl_t ctl0_r;
  logic [W-1:0]  simple0_r, quo0_r, dvs0_r, base0_r, ex0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.valid <= 1'b0;
    end else if (en) begin
      ctl0_r.valid <= ctl_nxt.valid;
    end
    if (en) begin
      ctl0_r.sel    <= ctl_nxt.sel;
      ctl0_r.status <= ctl_nxt.status;
      ctl0_r.neg    <= ctl_nxt.neg;
      simple0_r     <= simple_nxt;
      quo0_r        <= a_mag;
      dvs0_r        <= b_mag;
      base0_r       <= a;
      ex0_r         <= b;
    end
  end

  assign ctl_s[0]    = ctl0_r;
  assign simple_s[0] = simple0_r;
  assign rem_s[0]    = '0;
  assign quo_s[0]    = quo0_r;
  assign dvs_s[0]    = dvs0_r;
  assign acc_s[0]    = one_w;
  assign base_s[0]   = base0_r;
  assign ex_s[0]     = ex0_r;

  for (genvar i = 0; i < W; i++) begin : g_stage
    eia_stage #(.W(W)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ctl_i    (ctl_s[i]),
      .simple_i (simple_s[i]),
      .rem_i    (rem_s[i]),
      .quo_i    (quo_s[i]),
      .dvs_i    (dvs_s[i]),
      .acc_i    (acc_s[i]),
      .base_i   (base_s[i]),
      .ex_i     (ex_s[i]),
      .ctl_o    (ctl_s[i+1]),
      .simple_o (simple_s[i+1]),
      .rem_o    (rem_s[i+1]),
      .quo_o    (quo_s[i+1]),
      .dvs_o    (dvs_s[i+1]),
      .acc_o    (acc_s[i+1]),
      .base_o   (base_s[i+1]),
      .ex_o     (ex_s[i+1])
    );
  end

  // Output stage: sign correction and result selection.
  eia_pkg::ctl_t ctl_f;
  logic [W-1:0]  quo_f, rem_f, val_sel;
  logic          out_valid_r;
  logic [W-1:0]  out_value_r;
  eia_pkg::st_t  out_status_r;

  assign ctl_f = ctl_s[W];
  assign quo_f = ctl_f.neg ? W'(-quo_s[W]) : quo_s[W];
  assign rem_f = ctl_f.neg ? W'(-rem_s[W]) : rem_s[W];

  always_comb begin
    val_sel = simple_s[W];
    case (ctl_f.sel)
      eia_pkg::SEL_DIV: val_sel = quo_f;
      eia_pkg::SEL_MOD: val_sel = rem_f;
      eia_pkg::SEL_POW: val_sel = acc_s[W];
      default:          val_sel = simple_s[W];
    endcase
    if (ctl_f.status != eia_pkg::ST_OK) begin
      val_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r  <= val_sel;
      out_status_r <= ctl_f.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'({out_status_r, out_value_r});

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != eia_pkg::ST_OK |-> out_value_r == '0)
    else $error("error result with nonzero value");

  // The input side opens exactly when the output slot can advance.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_valid_r || out_tready))
    else $error("in_tready does not follow the pipeline enable");

  // No result appears right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid just after reset");

  // A frozen pipeline keeps the last stage unchanged.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctl_f.valid) && $stable(quo_s[W]))
    else $error("last stage moved during a stall");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for expression_integer_alu_top
// Directed corner requests followed by random ones drive the in_ stream while
// a predictor computes each expected value and status; the out_ stream is
// compared field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int W        = 32;
  localparam int OPW      = eia_pkg::OP_WIDTH;
  localparam int STW      = eia_pkg::ST_WIDTH;
  localparam int IN_BITS  = ((OPW + 2 * W + 7) / 8) * 8;
  localparam int OUT_BITS = ((W + STW + 7) / 8) * 8;
  localparam logic [W-1:0] INT_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ALL_ONE = {W{1'b1}};

  typedef struct packed {
    logic [4:0]   opcode;
    logic [W-1:0] lhs;
    logic [W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic [W-1:0]  value;
    eia_pkg::st_t  status;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_BITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int errors = 0;
  bit stim_done = 1'b0;
  int cycle_no = 0;

  expression_integer_alu_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Power by square and multiply; the product wraps at the data width.
  function automatic logic [W-1:0] wrap_power(logic [W-1:0] base, logic [W-1:0] ex);
    logic [W-1:0] acc;
    logic [W-1:0] sq;
    acc = W'(1);
    sq = base;
    for (int i = 0; i < W; i++) begin
      if (ex[i]) acc = W'(acc * sq);
      sq = W'(sq * sq);
    end
    return acc;
  endfunction

  // Computes the value and status that one request must produce.
  function automatic alu_res_t alu_predict(alu_req_t r);
    alu_res_t res;
    logic signed [W-1:0] sa;
    logic signed [W-1:0] sb;
    sa = r.lhs;
    sb = r.rhs;
    res.value = '0;
    res.status = eia_pkg::ST_OK;
    case (r.opcode)
      eia_pkg::OP_ADD: res.value = W'(r.lhs + r.rhs);
      eia_pkg::OP_SUB: res.value = W'(r.lhs - r.rhs);
      eia_pkg::OP_MUL: res.value = W'(r.lhs * r.rhs);
      eia_pkg::OP_DIV, eia_pkg::OP_MOD: begin
        if (r.rhs == '0) res.status = eia_pkg::ST_DIV0;
        else if (r.lhs == INT_MIN && r.rhs == ALL_ONE) begin
          // The quotient does not fit; the remainder is simply zero.
          if (r.opcode == eia_pkg::OP_DIV) res.status = eia_pkg::ST_OVERFLOW;
        end else if (r.opcode == eia_pkg::OP_DIV) res.value = W'(sa / sb);
        else res.value = W'(sa % sb);
      end
      eia_pkg::OP_POW: begin
        if (sb < 0) begin
          if (r.lhs == W'(1)) res.value = W'(1);
          else if (r.lhs == ALL_ONE) res.value = r.rhs[0] ? ALL_ONE : W'(1);
          else if (r.lhs == '0) res.status = eia_pkg::ST_DIV0;
        end else res.value = wrap_power(r.lhs, r.rhs);
      end
      eia_pkg::OP_INC: res.value = W'(r.lhs + W'(1));
      eia_pkg::OP_DEC: res.value = W'(r.lhs - W'(1));
      eia_pkg::OP_NOT: res.value = W'(r.lhs == '0);
      eia_pkg::OP_GT:  res.value = W'(sa > sb);
      eia_pkg::OP_GE:  res.value = W'(sa >= sb);
      eia_pkg::OP_LT:  res.value = W'(sa < sb);
      eia_pkg::OP_LE:  res.value = W'(sa <= sb);
      eia_pkg::OP_EQ:  res.value = W'(r.lhs == r.rhs);
      eia_pkg::OP_NE:  res.value = W'(r.lhs != r.rhs);
      eia_pkg::OP_AND: res.value = W'(r.lhs != '0 && r.rhs != '0);
      eia_pkg::OP_OR:  res.value = W'(r.lhs != '0 || r.rhs != '0);
      default: res.status = eia_pkg::ST_INVALID;
    endcase
    if (res.status != eia_pkg::ST_OK) res.value = '0;
    return res;
  endfunction

  // Splits a bus word into its fields, opcode in the lowest bits.
  function automatic alu_req_t unpack_req(logic [IN_BITS-1:0] d);
    alu_req_t r;
    r.opcode = d[OPW-1:0];
    r.lhs = d[OPW +: W];
    r.rhs = d[OPW+W +: W];
    return r;
  endfunction

  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return INT_MIN;
      1: return ~INT_MIN;
      2: return ALL_ONE;
      3: return '0;
      4: return W'(1);
      5, 6: return W'($signed($urandom_range(0, 20)) - 10);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_opcode();
    // Mostly defined operations, with the unused codes now and then.
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(eia_pkg::OP_OR + 1, 31));
    return 5'($urandom_range(0, eia_pkg::OP_OR));
  endfunction

  task automatic queue_req(logic [4:0] op, logic [W-1:0] a, logic [W-1:0] b);
    alu_req_t r;
    r.opcode = op;
    r.lhs = a;
    r.rhs = b;
    pending_reqs.push_back(r);
  endtask

  // Stimulus: directed corners first, then random requests.
  initial begin
    alu_req_t r;
    queue_req(eia_pkg::OP_ADD, ~INT_MIN, W'(1));
    queue_req(eia_pkg::OP_SUB, INT_MIN, W'(1));
    queue_req(eia_pkg::OP_MUL, ALL_ONE, ALL_ONE);
    queue_req(eia_pkg::OP_DIV, W'(7), '0);
    queue_req(eia_pkg::OP_MOD, INT_MIN, '0);
    queue_req(eia_pkg::OP_DIV, INT_MIN, ALL_ONE);
    queue_req(eia_pkg::OP_MOD, INT_MIN, ALL_ONE);
    queue_req(eia_pkg::OP_DIV, W'(-7), W'(2));
    queue_req(eia_pkg::OP_MOD, W'(-7), W'(2));
    queue_req(eia_pkg::OP_POW, '0, '0);
    queue_req(eia_pkg::OP_POW, W'(3), W'(40));
    queue_req(eia_pkg::OP_POW, W'(1), ALL_ONE);
    queue_req(eia_pkg::OP_POW, ALL_ONE, W'(-2));
    queue_req(eia_pkg::OP_POW, ALL_ONE, W'(-3));
    queue_req(eia_pkg::OP_POW, '0, INT_MIN);
    queue_req(eia_pkg::OP_POW, W'(5), W'(-1));
    queue_req(eia_pkg::OP_INC, ~INT_MIN, '0);
    queue_req(eia_pkg::OP_DEC, INT_MIN, '0);
    queue_req(eia_pkg::OP_NOT, '0, ALL_ONE);
    for (int op = eia_pkg::OP_GT; op <= eia_pkg::OP_OR; op++)
      queue_req(5'(op), INT_MIN, ~INT_MIN);
    queue_req(5'd31, ALL_ONE, ALL_ONE);
    for (int i = 0; i < 1500; i++) begin
      r.opcode = pick_opcode();
      r.lhs = pick_operand();
      r.rhs = pick_operand();
      pending_reqs.push_back(r);
    end
    stim_done = 1'b1;
  end

  // Idling is suppressed in a quiet window so back-to-back traffic occurs too.
  function automatic bit take_break();
    if (cycle_no > 300 && cycle_no < 900) return 1'b0;
    return $urandom_range(0, 99) < 10;
  endfunction

  // Presents the head of the request queue, which is never yet accepted.
  task automatic r_next();
    alu_req_t r;
    r = pending_reqs[0];
    in_tvalid <= 1'b1;
    in_tdata <= IN_BITS'({r.rhs, r.lhs, r.opcode});
  endtask

  // Driver: the head of the queue is the request on the bus until accepted.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == 8) rst_n <= 1'b1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(alu_predict(unpack_req(in_tdata)));
        void'(pending_reqs.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && !take_break()) begin
          r_next();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= !take_break();
    end
  end

  // Monitor: checks every accepted result against the oldest prediction.
  always @(posedge clk) begin
    alu_res_t got;
    alu_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[W-1:0];
      got.status = eia_pkg::st_t'(out_tdata[W+STW-1:W]);
      if (expected_results.size() == 0) begin
        $error("unexpected result value=%h status=%0d", got.value, got.status);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (got.value !== exp_res.value) begin
          $error("value: expected %h actual %h", exp_res.value, got.value);
          errors++;
        end
        if (got.status !== exp_res.status) begin
          $error("status: expected %0d actual %0d", exp_res.status, got.status);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done && rst_n);
    wait (pending_reqs.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("expression_integer_alu_top: match");
    end else begin
      $display("expression_integer_alu_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("expression_integer_alu_top: mismatch");
    $finish;
  end

endmodule

/* files.f */
sv/eia_pkg.sv
sv/eia_stage.sv
sv/expression_integer_alu_top.sv
test/tb_top.sv
